>>> hdl/bezier_easing_progress_defines.svh
// assertion macros for the easing progress block
`ifndef BEZIER_EASING_PROGRESS_DEFINES_SVH
`define BEZIER_EASING_PROGRESS_DEFINES_SVH

// condition holds at every edge out of reset
`define BEP_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BEP_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/bep_pkg.sv
// constants shared by the easing progress block
package bep_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int NEWTON_STEPS = 12;

  localparam int T_W     = FRAC_BITS + 1;
  localparam int ACC_W   = 22;
  localparam int REM_W   = 20;
  localparam int ITER_W  = $clog2(NEWTON_STEPS + 1);
  localparam int CNT_W   = $clog2(FRAC_BITS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam logic [T_W-1:0]          ONE_Q   = T_W'(1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0] TWO_ACC = ACC_W'(2 << FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_CTRL1_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL1_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL2_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL2_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION_MS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EASE_ENABLE = 3'd5;

  localparam logic [16:0]        RST_CTRL1_X     = 17'd35389;
  localparam logic signed [18:0] RST_CTRL1_Y     = 19'sd0;
  localparam logic [16:0]        RST_CTRL2_X     = 17'd22282;
  localparam logic signed [18:0] RST_CTRL2_Y     = 19'sd64881;
  localparam logic [15:0]        RST_DURATION_MS = 16'd3000;

endpackage

>>> hdl/bezier_easing_progress.sv
// eased transition progress through a cubic bezier solved by newton steps
//
// usage: pulse start with elapsed_ms while busy is low; the word is taken
// at that edge. the result word (progress, done_res) appears for one cycle
// with strobe high and must be taken then; the receiver cannot stall.
// a new word may be started in the same cycle as strobe.
// registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data
// while busy is low; cfg_ready is always high; unknown indexes are dropped.
// sequence from accept to strobe:
//   finished transition (elapsed >= duration): strobe straight from idle
//   linear mode: the time divider (16 quotient bits), then strobe
//   eased mode: the time divider, then n <= 12 newton steps and the y curve;
//   a step skips the divider when it saturates, and the loop may stop early
// one item at a time; the cost is set by the single shared multiplier
// (one product per cycle) and the one-bit-per-cycle restoring divider.
// reset restores the register defaults, returns to idle, drops any word.
module bezier_easing_progress (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [23:0]                   elapsed_ms,
  output logic                          strobe,
  output logic signed [18:0]            progress,
  output logic                          done_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bep_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bep_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bep_pkg::*;
  `include "bezier_easing_progress_defines.svh"

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_POST = 4'd2;
  localparam logic [3:0] S_M0   = 4'd3;
  localparam logic [3:0] S_M1   = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_M3   = 4'd6;
  localparam logic [3:0] S_M4   = 4'd7;
  localparam logic [3:0] S_M5   = 4'd8;
  localparam logic [3:0] S_B0   = 4'd9;
  localparam logic [3:0] S_B1   = 4'd10;
  localparam logic [3:0] S_D0   = 4'd11;
  localparam logic [3:0] S_D1   = 4'd12;
  localparam logic [3:0] S_D2   = 4'd13;
  localparam logic [3:0] S_CHK  = 4'd14;

  logic [16:0]        ctrl1_x;
  logic signed [18:0] ctrl1_y;
  logic [16:0]        ctrl2_x;
  logic signed [18:0] ctrl2_y;
  logic [15:0]        duration_ms;
  logic               ease_enable;

  logic [3:0]              state;
  logic [T_W-1:0]          t;
  logic [FRAC_BITS-1:0]    raw;
  logic [ITER_W-1:0]       iter;
  logic                    phase_y;
  logic                    div_raw;
  logic                    sat;
  logic                    neg;
  logic [CNT_W-1:0]        cnt;
  logic [REM_W-1:0]        rem;
  logic [REM_W-1:0]        dvs;
  logic [FRAC_BITS-1:0]    quo;
  logic [T_W-1:0]          m_mm, m_mt, m_tt, p_a, p_b, p_c;
  logic signed [ACC_W-1:0] acc, err, dx;

  logic [T_W-1:0]          mt;
  logic signed [17:0]      d21, omp2;
  logic signed [17:0]      a_op;
  logic signed [18:0]      b_op;
  logic signed [36:0]      prod;
  logic [36:0]             prod_mag;
  logic signed [ACC_W-1:0] mul_res, mul3;
  logic [REM_W:0]          rem_sh;
  logic                    rem_ge;
  logic [REM_W-1:0]        rem_next;
  logic [FRAC_BITS-1:0]    quo_next;
  logic signed [ACC_W-1:0] err_abs, dx_abs, y_sum;
  logic signed [18:0]      y_sat;
  logic signed [18:0]      t_ext, q_ext, tn;
  logic [T_W-1:0]          t_clamp;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1_x     <= RST_CTRL1_X;
      ctrl1_y     <= RST_CTRL1_Y;
      ctrl2_x     <= RST_CTRL2_X;
      ctrl2_y     <= RST_CTRL2_Y;
      duration_ms <= RST_DURATION_MS;
      ease_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CTRL1_X:     ctrl1_x     <= cfg_data[16:0];
        REG_CTRL1_Y:     ctrl1_y     <= $signed(cfg_data[18:0]);
        REG_CTRL2_X:     ctrl2_x     <= cfg_data[16:0];
        REG_CTRL2_Y:     ctrl2_y     <= $signed(cfg_data[18:0]);
        REG_DURATION_MS: duration_ms <= cfg_data[15:0];
        REG_EASE_ENABLE: ease_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign mt   = ONE_Q - t;
  assign d21  = $signed({1'b0, ctrl2_x}) - $signed({1'b0, ctrl1_x});
  assign omp2 = $signed({1'b0, ONE_Q}) - $signed({1'b0, ctrl2_x});

  // shared multiplier operand select
  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (state)
      S_M0: begin a_op = $signed({1'b0, mt});   b_op = $signed({2'b0, mt}); end
      S_M1: begin a_op = $signed({1'b0, mt});   b_op = $signed({2'b0, t});  end
      S_M2: begin a_op = $signed({1'b0, t});    b_op = $signed({2'b0, t});  end
      S_M3: begin a_op = $signed({1'b0, m_mm}); b_op = $signed({2'b0, t});  end
      S_M4: begin a_op = $signed({1'b0, m_mt}); b_op = $signed({2'b0, t});  end
      S_M5: begin a_op = $signed({1'b0, m_tt}); b_op = $signed({2'b0, t});  end
      S_B0: begin
        a_op = $signed({1'b0, p_a});
        b_op = phase_y ? ctrl1_y : $signed({2'b0, ctrl1_x});
      end
      S_B1: begin
        a_op = $signed({1'b0, p_b});
        b_op = phase_y ? ctrl2_y : $signed({2'b0, ctrl2_x});
      end
      S_D0: begin a_op = $signed({1'b0, m_mm}); b_op = $signed({2'b0, ctrl1_x}); end
      S_D1: begin a_op = $signed({1'b0, m_mt}); b_op = 19'(d21);  end
      S_D2: begin a_op = $signed({1'b0, m_tt}); b_op = 19'(omp2); end
      default: ;
    endcase
  end

  // product truncated toward zero
  assign prod     = a_op * b_op;
  assign prod_mag = prod[36] ? 37'(-prod) : 37'(prod);
  assign mul_res  = prod[36] ? -$signed({1'b0, prod_mag[36:FRAC_BITS]})
                             :  $signed({1'b0, prod_mag[36:FRAC_BITS]});
  assign mul3     = (mul_res <<< 1) + mul_res;

  // restoring divider step
  assign rem_sh   = {rem, 1'b0};
  assign rem_ge   = (rem_sh >= {1'b0, dvs});
  assign rem_next = rem_ge ? REM_W'(rem_sh - {1'b0, dvs}) : rem_sh[REM_W-1:0];
  assign quo_next = {quo[FRAC_BITS-2:0], rem_ge};

  assign err_abs = err[ACC_W-1] ? -err : err;
  assign dx_abs  = dx[ACC_W-1] ? -dx : dx;

  always_comb begin
    y_sum = acc + mul3;
    if (y_sum > TWO_ACC) begin
      y_sat = TWO_ACC[18:0];
    end else if (y_sum < -TWO_ACC) begin
      y_sat = 19'(-TWO_ACC);
    end else begin
      y_sat = y_sum[18:0];
    end
  end

  // newton update with clamp to the unit interval
  always_comb begin
    t_ext = $signed({2'b0, t});
    q_ext = $signed({3'b0, quo});
    tn    = neg ? t_ext + q_ext : t_ext - q_ext;
    if (sat) begin
      t_clamp = neg ? ONE_Q : '0;
    end else if (tn[18]) begin
      t_clamp = '0;
    end else if (tn > $signed({2'b0, ONE_Q})) begin
      t_clamp = ONE_Q;
    end else begin
      t_clamp = tn[T_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      strobe  <= 1'b0;
      t       <= '0;
      iter    <= '0;
      phase_y <= 1'b0;
      div_raw <= 1'b0;
      sat     <= 1'b0;
      cnt     <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (elapsed_ms >= {8'b0, duration_ms}) begin
              progress <= $signed({2'b0, ONE_Q});
              done_res <= 1'b1;
              strobe   <= 1'b1;
            end else begin
              rem     <= REM_W'(elapsed_ms[15:0]);
              dvs     <= REM_W'(duration_ms);
              div_raw <= 1'b1;
              cnt     <= '0;
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(FRAC_BITS - 1)) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          if (div_raw) begin
            if (ease_enable) begin
              t       <= {1'b0, quo};
              raw     <= quo;
              iter    <= '0;
              phase_y <= 1'b0;
              state   <= S_M0;
            end else begin
              progress <= $signed({3'b0, quo});
              done_res <= 1'b0;
              strobe   <= 1'b1;
              state    <= S_IDLE;
            end
          end else begin
            t    <= t_clamp;
            iter <= iter + 1'b1;
            if (iter + 1'b1 == ITER_W'(NEWTON_STEPS)) begin
              phase_y <= 1'b1;
            end
            state <= S_M0;
          end
        end
        S_M0: begin m_mm <= mul_res[T_W-1:0]; state <= S_M1; end
        S_M1: begin m_mt <= mul_res[T_W-1:0]; state <= S_M2; end
        S_M2: begin m_tt <= mul_res[T_W-1:0]; state <= S_M3; end
        S_M3: begin p_a  <= mul_res[T_W-1:0]; state <= S_M4; end
        S_M4: begin p_b  <= mul_res[T_W-1:0]; state <= S_M5; end
        S_M5: begin p_c  <= mul_res[T_W-1:0]; state <= S_B0; end
        S_B0: begin
          acc   <= $signed({5'b0, p_c}) + mul3;
          state <= S_B1;
        end
        S_B1: begin
          acc <= y_sum;
          if (phase_y) begin
            progress <= y_sat;
            done_res <= 1'b0;
            strobe   <= 1'b1;
            state    <= S_IDLE;
          end else begin
            state <= S_D0;
          end
        end
        S_D0: begin
          err   <= acc - $signed({6'b0, raw});
          dx    <= mul3;
          state <= S_D1;
        end
        S_D1: begin
          dx    <= dx + (mul3 <<< 1);
          state <= S_D2;
        end
        S_D2: begin
          dx    <= dx + mul3;
          state <= S_CHK;
        end
        S_CHK: begin
          if (err == '0 || dx == '0) begin
            phase_y <= 1'b1;
            state   <= S_M0;
          end else begin
            neg     <= err[ACC_W-1] ^ dx[ACC_W-1];
            div_raw <= 1'b0;
            if (err_abs >= dx_abs) begin
              sat   <= 1'b1;
              state <= S_POST;
            end else begin
              sat   <= 1'b0;
              rem   <= err_abs[REM_W-1:0];
              dvs   <= dx_abs[REM_W-1:0];
              cnt   <= '0;
              state <= S_DIV;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BEP_ALWAYS(a_t_in_range, t <= ONE_Q, "newton estimate left the unit interval")
  `BEP_ALWAYS(a_iter_bound, iter <= ITER_W'(NEWTON_STEPS), "newton step count overran")
  `BEP_IMPLY(a_rem_below, state == S_DIV, rem < dvs, "divider remainder not below divisor")
  `BEP_IMPLY(a_out_sat, strobe,
             progress <= $signed(TWO_ACC[18:0]) && progress >= 19'(-TWO_ACC),
             "progress word outside saturation range")
  `BEP_IMPLY(a_done_one, strobe && done_res, progress == $signed({2'b0, ONE_Q}),
             "finished word without full progress")

endmodule

>>> tb/tb_bezier_easing_progress.sv
// testbench for bezier_easing_progress: bit-exact prediction of every progress word
`timescale 1ns / 1ps

module tb_bezier_easing_progress;
  import bep_pkg::*;

  localparam longint UNIT_Q = longint'(1) << FRAC_BITS;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [23:0]        elapsed;
    logic signed [18:0] progress;
    logic               done_res;
  } progress_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [23:0] elapsed_ms = '0;
  logic strobe;
  logic signed [18:0] progress;
  logic done_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [16:0]        cur_c1x = RST_CTRL1_X;
  logic signed [18:0] cur_c1y = RST_CTRL1_Y;
  logic [16:0]        cur_c2x = RST_CTRL2_X;
  logic signed [18:0] cur_c2y = RST_CTRL2_Y;
  logic [15:0]        cur_dur = RST_DURATION_MS;
  logic               cur_ease = 1'b1;

  logic [23:0]    elapsed_pending[$];
  progress_word_t progress_due[$];
  int errors = 0;
  int idle_odds = 0;
  int gap_left = 0;
  int quiet_cycles = 0;

  bezier_easing_progress dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .elapsed_ms(elapsed_ms),
    .strobe(strobe), .progress(progress), .done_res(done_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint q_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    if (p < 0) return -((-p) >>> FRAC_BITS);
    return p >>> FRAC_BITS;
  endfunction

  function automatic longint bez_curve(input longint t, input longint c1, input longint c2);
    longint mt;
    mt = UNIT_Q - t;
    return 3 * q_mul(q_mul(q_mul(mt, mt), t), c1)
         + 3 * q_mul(q_mul(q_mul(mt, t), t), c2)
         + q_mul(q_mul(t, t), t);
  endfunction

  function automatic longint eased_progress(input longint raw);
    longint p1x, p2x, t, mt, err, dx;
    p1x = longint'(cur_c1x);
    p2x = longint'(cur_c2x);
    t = raw;
    for (int i = 0; i < NEWTON_STEPS; i++) begin
      mt = UNIT_Q - t;
      err = bez_curve(t, p1x, p2x) - raw;
      dx = 3 * q_mul(q_mul(mt, mt), p1x)
         + 6 * q_mul(q_mul(mt, t), p2x - p1x)
         + 3 * q_mul(q_mul(t, t), UNIT_Q - p2x);
      if (err == 0 || dx == 0) break;
      t = t - (err * UNIT_Q) / dx;
      if (t < 0) t = 0;
      if (t > UNIT_Q) t = UNIT_Q;
    end
    return bez_curve(t, longint'(cur_c1y), longint'(cur_c2y));
  endfunction

  function automatic progress_word_t predict_word(input logic [23:0] el);
    progress_word_t w;
    longint raw, prog;
    w.elapsed = el;
    w.done_res = 1'b0;
    if (cur_dur == 0) begin
      prog = UNIT_Q;
      w.done_res = 1'b1;
    end else begin
      raw = (longint'(el) << FRAC_BITS) / longint'(cur_dur);
      if (raw >= UNIT_Q) begin
        prog = UNIT_Q;
        w.done_res = 1'b1;
      end else if (cur_ease) begin
        prog = eased_progress(raw);
      end else begin
        prog = raw;
      end
    end
    if (prog > 2 * UNIT_Q) prog = 2 * UNIT_Q;
    if (prog < -2 * UNIT_Q) prog = -2 * UNIT_Q;
    w.progress = prog[18:0];
    return w;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        progress_due.push_back(predict_word(elapsed_ms));
        void'(elapsed_pending.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (elapsed_pending.size() > 0) begin
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          gap_left <= $urandom_range(0, 7);
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          elapsed_ms <= elapsed_pending[0];
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    progress_word_t w;
    if (!rst && strobe) begin
      if (progress_due.size() == 0) begin
        if (errors < 10) $display("unexpected word: progress %0d done %0b", progress, done_res);
        errors <= errors + 1;
      end else begin
        w = progress_due.pop_front();
        if (progress !== w.progress || done_res !== w.done_res) begin
          if (errors < 10)
            $display("mismatch elapsed %0d: expected progress %0d done %0b, got %0d %0b",
                     w.elapsed, w.progress, w.done_res, progress, done_res);
          errors <= errors + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CTRL1_X:     cur_c1x = data[16:0];
      REG_CTRL1_Y:     cur_c1y = data;
      REG_CTRL2_X:     cur_c2x = data[16:0];
      REG_CTRL2_Y:     cur_c2y = data;
      REG_DURATION_MS: cur_dur = data[15:0];
      REG_EASE_ENABLE: cur_ease = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int c1x, input int c1y, input int c2x, input int c2y,
                              input int dur, input int ease_on);
    write_reg(REG_CTRL1_X, 19'(c1x));
    write_reg(REG_CTRL1_Y, 19'(c1y));
    write_reg(REG_CTRL2_X, 19'(c2x));
    write_reg(REG_CTRL2_Y, 19'(c2y));
    write_reg(REG_DURATION_MS, 19'(dur));
    write_reg(REG_EASE_ENABLE, 19'(ease_on));
  endtask

  task automatic wait_idle();
    while (elapsed_pending.size() != 0 || progress_due.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int rand_ctrl_x();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 65536);
    return $urandom_range(0, 131071);
  endfunction

  function automatic int rand_ctrl_y();
    if ($urandom_range(0, 9) < 7) return int'($urandom_range(0, 262144)) - 131072;
    return int'($urandom_range(0, 524287));
  endfunction

  function automatic int rand_duration();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 0;
    if (pick < 30) return $urandom_range(1, 64);
    if (pick < 70) return $urandom_range(1, 4000);
    return $urandom_range(1, 65535);
  endfunction

  function automatic logic [23:0] rand_elapsed();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80 && cur_dur != 0) return 24'($urandom_range(0, cur_dur - 1));
    if (pick < 88) return 24'(cur_dur) + 24'($urandom_range(0, 2));
    return 24'($urandom);
  endfunction

  task automatic random_phase(input int n, input int odds);
    wait_idle();
    idle_odds = odds;
    apply_config(rand_ctrl_x(), rand_ctrl_y(), rand_ctrl_x(), rand_ctrl_y(),
                 rand_duration(), ($urandom_range(0, 99) < 85) ? 1 : 0);
    for (int i = 0; i < n; i++) elapsed_pending.push_back(rand_elapsed());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    idle_odds = 4;

    // reset defaults, both sides of the finish point
    elapsed_pending.push_back(24'd0);
    elapsed_pending.push_back(24'd1);
    elapsed_pending.push_back(24'd1500);
    elapsed_pending.push_back(24'd2999);
    elapsed_pending.push_back(24'd3000);
    elapsed_pending.push_back(24'hFFFFFF);
    wait_idle();

    // zero duration, spare indexes ignored
    write_reg(REG_SPARE_LO, 19'h7FFFF);
    write_reg(REG_SPARE_HI, 19'h2AAAA);
    apply_config(0, 0, 65536, 65536, 0, 1);
    elapsed_pending.push_back(24'd0);
    elapsed_pending.push_back(24'hFFFFFF);
    wait_idle();

    // shortest duration
    apply_config(65536, 131072, 0, -131072, 1, 1);
    elapsed_pending.push_back(24'd0);
    elapsed_pending.push_back(24'd1);
    wait_idle();

    // longest duration, flat x, large positive y saturates
    apply_config(0, 262143, 0, 262143, 65535, 1);
    elapsed_pending.push_back(24'd0);
    elapsed_pending.push_back(24'd32768);
    elapsed_pending.push_back(24'd65534);
    wait_idle();

    // control x beyond one, large negative y saturates
    apply_config(131071, -262144, 131071, -262144, 65535, 1);
    elapsed_pending.push_back(24'd16384);
    elapsed_pending.push_back(24'd49152);
    wait_idle();

    // overshooting curve
    apply_config(65536, -131072, 0, 131072, 60000, 1);
    elapsed_pending.push_back(24'd20000);
    elapsed_pending.push_back(24'd40000);
    wait_idle();

    // linear mode
    apply_config(35389, 0, 22282, 64881, 65535, 0);
    elapsed_pending.push_back(24'd100);
    elapsed_pending.push_back(24'd65534);
    elapsed_pending.push_back(24'd65535);
    wait_idle();

    for (int p = 0; p < 9; p++) random_phase(100, (p % 3 == 2) ? 0 : $urandom_range(2, 6));
    random_phase(100, 0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && progress_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> bezier_easing_progress.f
+incdir+hdl
hdl/bep_pkg.sv
hdl/bezier_easing_progress.sv
tb/tb_bezier_easing_progress.sv
